FILE: src/bmfe_pkg.sv
// shared types, constants and helpers for the biphase-mark frame encoder
package bmfe_pkg;

	// start byte as packed for each bit order
	localparam logic [7:0] START_MSB = 8'h77;
	localparam logic [7:0] START_LSB = 8'hEE;
	localparam logic [3:0] FULL_BITS = 4'd8;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} bmfe_in_t;

	// output word
	typedef struct packed {
		logic [7:0] packed_byte;
		logic [3:0] valid_bits;
		logic       frame_end;
	} bmfe_out_t;

	// one packer command per cycle from the sequencer
	typedef struct packed {
		logic start;      // emit the start byte
		logic push;       // push one line half-bit
		logic flush;      // emit the partial byte, close the frame
		logic level;      // half-bit level for push
		logic final_half; // last half-bit of the frame
	} bmfe_cmd_t;

	// number of significant bits of an 8-bit value
	function automatic logic [3:0] sig_bits(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) n = 4'(i + 1);
		end
		return n;
	endfunction

endpackage

FILE: src/biphase_mark_frame_encoder.sv
// top level of the biphase-mark frame encoder
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  in       | in_valid/in_ready   | in_data: data_byte, last_byte
//  out      | out_valid/out_ready | out_data: packed_byte, valid_bits, frame_end
//  config   | cfg_we              | cfg_wdata: msb_first
//
// in the data, mark and end phases one line half-bit is produced per cycle
// while the output register can take it; a byte passes an accept step, two
// half-bits per significant bit, a data-close step and, but for the last byte,
// the inter-byte mark; a frame adds the start byte and the end mark and flush
// sequencer commands wait while the output register is full and not taken
// reset returns the line high, the frame closed and msb_first to 0
module biphase_mark_frame_encoder import bmfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bmfe_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output bmfe_out_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	logic      msb_first_q;
	logic      pk_ready;
	bmfe_cmd_t cmd;

	// bit order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) msb_first_q <= 1'b0;
		else if (cfg_we) msb_first_q <= cfg_wdata;
	end

	bmfe_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.msb_first (msb_first_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.pk_ready  (pk_ready),
		.cmd       (cmd)
	);

	bmfe_packer u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.msb_first (msb_first_q),
		.cmd       (cmd),
		.pk_ready  (pk_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: src/bmfe_packer.sv
// packs line half-bits into bytes and holds the output register
module bmfe_packer import bmfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msb_first,
	input  bmfe_cmd_t cmd,
	output logic      pk_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output bmfe_out_t out_data
);

	logic [7:0] acc_q;
	logic [2:0] pos_q;
	logic       out_valid_q;
	bmfe_out_t  out_q;
	logic [2:0] bit_idx;
	logic [7:0] acc_nx;

	// new word may be written when the output register is empty or draining
	assign pk_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// placement of the current half-bit
	always_comb begin
		bit_idx = msb_first ? ~pos_q : pos_q;
		acc_nx = acc_q;
		acc_nx[bit_idx] = cmd.level;
	end

	// accumulator and bit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (pk_ready) begin
				if (cmd.start) begin
					out_valid_q <= 1'b1;
					acc_q <= '0;
					pos_q <= '0;
				end else if (cmd.push) begin
					if (pos_q == 3'd7) begin
						out_valid_q <= 1'b1;
						acc_q <= '0;
						pos_q <= '0;
					end else begin
						acc_q <= acc_nx;
						pos_q <= pos_q + 3'd1;
					end
				end else if (cmd.flush) begin
					if (pos_q != 3'd0) out_valid_q <= 1'b1;
					acc_q <= '0;
					pos_q <= '0;
				end
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (pk_ready) begin
			if (cmd.start) begin
				out_q.packed_byte <= msb_first ? START_MSB : START_LSB;
				out_q.valid_bits  <= FULL_BITS;
				out_q.frame_end   <= 1'b0;
			end else if (cmd.push && pos_q == 3'd7) begin
				out_q.packed_byte <= acc_nx;
				out_q.valid_bits  <= FULL_BITS;
				out_q.frame_end   <= cmd.final_half;
			end else if (cmd.flush && pos_q != 3'd0) begin
				out_q.packed_byte <= acc_q;
				out_q.valid_bits  <= {1'b0, pos_q};
				out_q.frame_end   <= 1'b1;
			end
		end
	end

endmodule

FILE: src/bmfe_sequencer.sv
// symbol shift register and half-bit sequencer
module bmfe_sequencer import bmfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msb_first,
	input  logic      in_valid,
	output logic      in_ready,
	input  bmfe_in_t  in_data,
	input  logic      pk_ready,
	output bmfe_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_DATA  = 6'b000100,
		S_MARK  = 6'b001000,
		S_END   = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t     state_q;
	logic [7:0] sym_q;
	logic [3:0] cnt_q;
	logic       half_q;
	logic [2:0] ctr_q;
	logic       line_q;
	logic       open_q;
	logic       last_q;

	logic [7:0] mag;
	logic       big;
	logic [7:0] sym_raw;
	logic [3:0] nb;
	logic [7:0] sym_load;
	logic       cur_bit;
	logic       second;
	logic [2:0] end_len;
	logic       accept;

	// magnitude, symbol and width of the incoming byte
	always_comb begin
		big      = in_data.data_byte > 8'd128;
		mag      = 8'd0 - in_data.data_byte;
		sym_raw  = big ? ~mag : in_data.data_byte;
		nb       = sig_bits(big ? mag : in_data.data_byte);
		sym_load = msb_first ? 8'(sym_raw << (4'd8 - nb)) : sym_raw;
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign cur_bit  = msb_first ? sym_q[7] : sym_q[0];
	assign second   = cur_bit ? line_q : ~line_q;
	assign end_len  = line_q ? 3'd5 : 3'd6;

	// packer command for the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: ;
			S_START: cmd.start = 1'b1;
			S_DATA: begin
				cmd.push  = (cnt_q != 4'd0);
				cmd.level = half_q ? second : ~line_q;
			end
			S_MARK: begin
				cmd.push  = 1'b1;
				cmd.level = ~line_q;
			end
			S_END: begin
				cmd.push       = 1'b1;
				cmd.level      = (ctr_q < 3'd4) ? ~line_q : (ctr_q == 3'd4 ? line_q : 1'b1);
				cmd.final_half = (ctr_q == end_len - 3'd1);
			end
			S_FLUSH: cmd.flush = 1'b1;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sym_q   <= '0;
			cnt_q   <= '0;
			half_q  <= 1'b0;
			ctr_q   <= '0;
			line_q  <= 1'b1;
			open_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sym_q   <= sym_load;
						cnt_q   <= nb;
						half_q  <= 1'b0;
						last_q  <= in_data.last_byte;
						state_q <= open_q ? S_DATA : S_START;
					end
				end
				S_START: begin
					if (pk_ready) begin
						open_q  <= 1'b1;
						line_q  <= 1'b1;
						state_q <= S_DATA;
					end
				end
				S_DATA: begin
					if (cnt_q == 4'd0) begin
						ctr_q   <= '0;
						state_q <= last_q ? S_END : S_MARK;
					end else if (pk_ready) begin
						if (!half_q) begin
							half_q <= 1'b1;
						end else begin
							half_q <= 1'b0;
							line_q <= second;
							cnt_q  <= cnt_q - 4'd1;
							sym_q  <= msb_first ? {sym_q[6:0], 1'b0} : {1'b0, sym_q[7:1]};
						end
					end
				end
				S_MARK: begin
					if (pk_ready) begin
						if (ctr_q == 3'd2) begin
							line_q  <= ~line_q;
							state_q <= S_IDLE;
						end else begin
							ctr_q <= ctr_q + 3'd1;
						end
					end
				end
				S_END: begin
					if (pk_ready) begin
						if (ctr_q == end_len - 3'd1) state_q <= S_FLUSH;
						else ctr_q <= ctr_q + 3'd1;
					end
				end
				S_FLUSH: begin
					if (pk_ready) begin
						line_q  <= 1'b1;
						open_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
